FILE: sv/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Types, constants and helpers shared by the program stream demux files.
// ----------------------------------------------------------------------------
package psd_pkg;

   localparam int unsigned MAX_UNIT_BYTES = 1048576;
   localparam int unsigned COUNT_W        = $clog2(MAX_UNIT_BYTES + 1);
   localparam int unsigned STAMP_W        = 33;
   localparam int unsigned UNIT_LEN_W     = 21;
   localparam int unsigned CSR_ADDR_W     = 1;

   localparam logic [31:0] PACK_CODE      = 32'h0000_01BA;
   localparam logic [23:0] START_PREFIX   = 24'h00_0001;
   localparam logic [7:0]  PRIV_STREAM_1  = 8'hBD;
   localparam logic [7:0]  PRIV_STREAM_2  = 8'hBF;
   localparam logic [7:0]  VIDEO_ID_RESET = 8'hE0;
   localparam logic [7:0]  AUDIO_ID_RESET = 8'hC0;
   localparam logic [1:0]  FLAGS_BAD      = 2'd1;
   localparam logic [1:0]  FLAGS_BOTH     = 2'd3;
   localparam logic [7:0]  PTS_POS        = 8'd5;
   localparam logic [7:0]  DTS_POS        = 8'd10;

   localparam logic [CSR_ADDR_W-1:0] CSR_VIDEO_ID = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_AUDIO_ID = CSR_ADDR_W'(1);

   typedef enum logic [3:0] {
      PH_HUNT, PH_SCAN, PH_LEN_HI, PH_LEN_LO, PH_OPT1, PH_OPT2, PH_OPT3,
      PH_HDR, PH_PAY, PH_CHECK, PH_PLEN_HI, PH_PLEN_LO, PH_PSKIP
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_DONE    = 2'd1,
      KIND_ABANDON = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type               result_kind;
      logic                   is_audio;
      logic [7:0]             payload_byte;
      logic [STAMP_W-1:0]     presentation_stamp;
      logic [STAMP_W-1:0]     decode_stamp;
      logic [UNIT_LEN_W-1:0]  unit_length;
   } result_type;

   typedef struct packed {
      logic [7:0] video_id;
      logic [7:0] audio_id;
   } stream_ids_type;

   // 5 header bytes -> 33-bit time stamp, marker bits dropped
   function automatic logic [STAMP_W-1:0] take_stamp(input logic [39:0] s);
      take_stamp = {s[35:33], s[31:24], s[23:17], s[15:8], s[7:1]};
   endfunction

endpackage

FILE: sv/psd_req_if.sv
// ----------------------------------------------------------------------------
// psd_req_if
// Program stream byte channel.
// ----------------------------------------------------------------------------
interface psd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       chunk_last;

   modport source (output valid, output data_byte, output chunk_last, input ready);
   modport sink (input valid, input data_byte, input chunk_last, output ready);
endinterface

FILE: sv/psd_rsp_if.sv
// ----------------------------------------------------------------------------
// psd_rsp_if
// Elementary stream result channel.
// ----------------------------------------------------------------------------
interface psd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         result_kind;
   logic                               is_audio;
   logic [7:0]                         payload_byte;
   logic [psd_pkg::STAMP_W-1:0]        presentation_stamp;
   logic [psd_pkg::STAMP_W-1:0]        decode_stamp;
   logic [psd_pkg::UNIT_LEN_W-1:0]     unit_length;

   modport source (output valid, output result_kind, output is_audio, output payload_byte,
                   output presentation_stamp, output decode_stamp, output unit_length,
                   input ready);
   modport sink (input valid, input result_kind, input is_audio, input payload_byte,
                 input presentation_stamp, input decode_stamp, input unit_length,
                 output ready);
endinterface

FILE: sv/psd_csr_if.sv
// ----------------------------------------------------------------------------
// psd_csr_if
// Register write channel.
// ----------------------------------------------------------------------------
interface psd_csr_if;
   logic                            valid;
   logic                            ready;
   logic [psd_pkg::CSR_ADDR_W-1:0]  index;
   logic [7:0]                      data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/program_stream_demux.sv
// ----------------------------------------------------------------------------
// program_stream_demux
// MPEG-2 program stream to elementary stream demultiplexer.
// ----------------------------------------------------------------------------
// Takes one stream byte per clock while the result queue can take a word,
// and returns at most one word per byte: a payload byte, a completed unit
// with its stamps and length, or an abandoned unit after lost sync. A byte
// goes through the input register, the parser and a two-word result queue;
// the parser state registers update once per byte, so the sustained rate is
// one byte per cycle when not stalled. Stream ids are to be written on the
// register port while the block is idle; the block does not enforce it.
module program_stream_demux (
   input logic          clock,
   input logic          reset,
   psd_req_if.sink      req_port,
   psd_rsp_if.source    rsp_port,
   psd_csr_if.sink      csr_port
);
   import psd_pkg::*;

   stream_ids_type ids;
   logic           push_ok;
   logic           res_valid;
   result_type     res_data;
   result_type     out_data;

   assign csr_port.ready = 1'b1;

   psd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_port.valid),
      .wr_index (csr_port.index),
      .wr_data  (csr_port.data),
      .ids      (ids)
   );

   psd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_port.valid),
      .in_byte   (req_port.data_byte),
      .in_ready  (req_port.ready),
      .ids       (ids),
      .push_ok   (push_ok),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   psd_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res_data),
      .push_ok   (push_ok),
      .pop_valid (rsp_port.valid),
      .pop_ready (rsp_port.ready),
      .pop_data  (out_data)
   );

   assign rsp_port.result_kind        = out_data.result_kind;
   assign rsp_port.is_audio           = out_data.is_audio;
   assign rsp_port.payload_byte       = out_data.payload_byte;
   assign rsp_port.presentation_stamp = out_data.presentation_stamp;
   assign rsp_port.decode_stamp       = out_data.decode_stamp;
   assign rsp_port.unit_length        = out_data.unit_length;

endmodule

FILE: sv/psd_csr.sv
// ----------------------------------------------------------------------------
// psd_csr
// Stream id registers, written one word at a time.
// ----------------------------------------------------------------------------
module psd_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_valid,
   input  logic [psd_pkg::CSR_ADDR_W-1:0]  wr_index,
   input  logic [7:0]                      wr_data,
   output psd_pkg::stream_ids_type         ids
);
   import psd_pkg::*;

   stream_ids_type ids_ff, ids_in;

   always_comb begin
      ids_in = ids_ff;
      if (wr_valid) begin
         unique case (wr_index)
            CSR_VIDEO_ID: ids_in.video_id = wr_data;
            CSR_AUDIO_ID: ids_in.audio_id = wr_data;
            default: ids_in = ids_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ids_ff.video_id <= VIDEO_ID_RESET;
         ids_ff.audio_id <= AUDIO_ID_RESET;
      end else begin
         ids_ff <= ids_in;
      end
   end

   assign ids = ids_ff;

endmodule

FILE: sv/psd_parser.sv
// ----------------------------------------------------------------------------
// psd_parser
// Input register and pack/PES parser, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module psd_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic [7:0]               in_byte,
   output logic                     in_ready,
   input  psd_pkg::stream_ids_type  ids,
   input  logic                     push_ok,
   output logic                     res_valid,
   output psd_pkg::result_type      res_data
);
   import psd_pkg::*;

   logic               in_valid_ff;
   logic [7:0]         in_byte_ff;
   logic               adv;

   phase_type          phase_ff, phase_in;
   logic [31:0]        win_ff, win_in;
   logic [15:0]        pes_left_ff, pes_left_in;
   logic [7:0]         hdr_left_ff, hdr_left_in;
   logic [1:0]         flags_ff, flags_in;
   logic [39:0]        shift_ff, shift_in;
   logic [STAMP_W-1:0] pts_ff, pts_in, dts_ff, dts_in;
   logic               audio_ff, audio_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]         hdr_pos_ff, hdr_pos_in;
   logic [1:0]         check_cnt_ff, check_cnt_in;
   logic               open_ff, open_in;

   logic [7:0]  b;
   logic [31:0] win;
   logic        prefix;
   logic [7:0]  id;
   logic [15:0] pes_dec;
   logic        pes_end;
   logic [7:0]  hdr_dec;
   logic        is_pack, is_vid, is_aud, is_priv;
   logic        check_done, check_bad, unit_close;

   assign adv      = in_valid_ff && push_ok;
   assign in_ready = !in_valid_ff || adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         in_byte_ff <= in_byte;
      end
   end

   assign b          = in_byte_ff;
   assign win        = {win_ff[23:0], b};
   assign prefix     = win[31:8] == START_PREFIX;
   assign id         = win[7:0];
   assign pes_dec    = pes_left_ff - 16'd1;
   assign pes_end    = pes_dec == 16'd0;
   assign hdr_dec    = hdr_left_ff - 8'd1;
   assign is_pack    = win == PACK_CODE;
   assign is_vid     = prefix && id == ids.video_id;
   assign is_aud     = prefix && !is_vid && id == ids.audio_id;
   assign is_priv    = prefix && !is_vid && !is_aud &&
                       (id == PRIV_STREAM_1 || id == PRIV_STREAM_2);
   assign check_done = check_cnt_ff == 2'd3;
   assign check_bad  = !(is_pack || is_vid || is_aud || is_priv);
   assign unit_close = open_ff && (audio_ff || is_pack || is_aud);

   // next state
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_HUNT:    if (is_pack) phase_in = PH_SCAN;
         PH_SCAN:    if (prefix && (id == ids.video_id || id == ids.audio_id))
                        phase_in = PH_LEN_HI;
         PH_LEN_HI:  phase_in = PH_LEN_LO;
         PH_LEN_LO:  phase_in = ({pes_left_ff[15:8], b} == 16'd0) ? PH_CHECK : PH_OPT1;
         PH_OPT1:    phase_in = pes_end ? PH_CHECK : PH_OPT2;
         PH_OPT2:    phase_in = pes_end ? PH_CHECK : PH_OPT3;
         PH_OPT3:    phase_in = pes_end ? PH_CHECK : ((b != 8'd0) ? PH_HDR : PH_PAY);
         PH_HDR:     phase_in = pes_end ? PH_CHECK : ((hdr_dec == 8'd0) ? PH_PAY : PH_HDR);
         PH_PAY:     if (pes_end) phase_in = PH_CHECK;
         PH_CHECK: begin
            if (check_done) begin
               if (check_bad)     phase_in = PH_HUNT;
               else if (is_pack)  phase_in = PH_SCAN;
               else if (is_priv)  phase_in = PH_PLEN_HI;
               else               phase_in = PH_LEN_HI;
            end
         end
         PH_PLEN_HI: phase_in = PH_PLEN_LO;
         PH_PLEN_LO: phase_in = ({pes_left_ff[15:8], b} == 16'd0) ? PH_CHECK : PH_PSKIP;
         PH_PSKIP:   if (pes_end) phase_in = PH_CHECK;
         default:    phase_in = PH_HUNT;
      endcase
   end

   // datapath and result
   always_comb begin
      win_in       = win;
      pes_left_in  = pes_left_ff;
      hdr_left_in  = hdr_left_ff;
      flags_in     = flags_ff;
      shift_in     = shift_ff;
      pts_in       = pts_ff;
      dts_in       = dts_ff;
      audio_in     = audio_ff;
      count_in     = count_ff;
      hdr_pos_in   = hdr_pos_ff;
      check_cnt_in = 2'd0;
      open_in      = open_ff;
      res_valid    = 1'b0;
      res_data     = '0;
      res_data.result_kind        = KIND_PAYLOAD;
      res_data.is_audio           = audio_ff;
      res_data.presentation_stamp = pts_ff;
      res_data.decode_stamp       = dts_ff;
      res_data.unit_length        = UNIT_LEN_W'(count_ff);

      unique case (phase_ff)
         PH_SCAN: begin
            if (prefix && (id == ids.video_id || id == ids.audio_id))
               audio_in = id != ids.video_id;
         end
         PH_LEN_HI, PH_PLEN_HI: pes_left_in = {b, 8'd0};
         PH_LEN_LO: begin
            pes_left_in = {pes_left_ff[15:8], b};
            flags_in    = 2'd0;
            if (pes_left_in == 16'd0) open_in = 1'b1;
         end
         PH_PLEN_LO: pes_left_in = {pes_left_ff[15:8], b};
         PH_OPT1, PH_OPT2, PH_OPT3, PH_HDR, PH_PAY: begin
            pes_left_in = pes_dec;
            if (phase_ff == PH_OPT2) begin
               flags_in = b[7:6];
               if (b[7:6] != FLAGS_BAD) begin
                  pts_in = '0;
                  dts_in = '0;
               end
            end
            if (phase_ff == PH_OPT3) begin
               hdr_left_in = b;
               hdr_pos_in  = 8'd0;
               shift_in    = '0;
            end
            if (phase_ff == PH_HDR) begin
               shift_in    = {shift_ff[31:0], b};
               hdr_pos_in  = (hdr_pos_ff != 8'hFF) ? hdr_pos_ff + 8'd1 : hdr_pos_ff;
               hdr_left_in = hdr_dec;
               if (hdr_pos_in == PTS_POS && flags_ff[1]) pts_in = take_stamp(shift_in);
               if (hdr_pos_in == DTS_POS && flags_ff == FLAGS_BOTH)
                  dts_in = take_stamp(shift_in);
            end
            if (phase_ff == PH_PAY && flags_ff != FLAGS_BAD) begin
               res_valid                   = 1'b1;
               res_data.payload_byte       = b;
               res_data.presentation_stamp = '0;
               res_data.decode_stamp       = '0;
               res_data.unit_length        = '0;
               if (count_ff < COUNT_W'(MAX_UNIT_BYTES)) count_in = count_ff + COUNT_W'(1);
            end
            if (pes_end && flags_in != FLAGS_BAD) open_in = 1'b1;
         end
         PH_PSKIP: pes_left_in = pes_dec;
         PH_CHECK: begin
            check_cnt_in = check_cnt_ff + 2'd1;
            if (check_done) begin
               check_cnt_in = 2'd0;
               if (check_bad) begin
                  res_valid            = 1'b1;
                  res_data.result_kind = KIND_ABANDON;
                  count_in             = '0;
                  open_in              = 1'b0;
                  pts_in               = '0;
                  dts_in               = '0;
                  win_in               = '1;
               end else begin
                  if (unit_close) begin
                     res_valid            = 1'b1;
                     res_data.result_kind = KIND_DONE;
                     count_in             = '0;
                     open_in              = 1'b0;
                  end
                  if (!is_pack && !is_priv) audio_in = is_aud;
               end
            end
         end
         default: ;
      endcase
      res_valid = res_valid && adv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         win_ff       <= '1;
         pes_left_ff  <= '0;
         hdr_left_ff  <= '0;
         flags_ff     <= '0;
         shift_ff     <= '0;
         pts_ff       <= '0;
         dts_ff       <= '0;
         audio_ff     <= 1'b0;
         count_ff     <= '0;
         hdr_pos_ff   <= '0;
         check_cnt_ff <= '0;
         open_ff      <= 1'b0;
      end else if (adv) begin
         phase_ff     <= phase_in;
         win_ff       <= win_in;
         pes_left_ff  <= pes_left_in;
         hdr_left_ff  <= hdr_left_in;
         flags_ff     <= flags_in;
         shift_ff     <= shift_in;
         pts_ff       <= pts_in;
         dts_ff       <= dts_in;
         audio_ff     <= audio_in;
         count_ff     <= count_in;
         hdr_pos_ff   <= hdr_pos_in;
         check_cnt_ff <= check_cnt_in;
         open_ff      <= open_in;
      end
   end

endmodule

FILE: sv/psd_out_fifo.sv
// ----------------------------------------------------------------------------
// psd_out_fifo
// Two-word result queue between the parser and the result channel.
// ----------------------------------------------------------------------------
module psd_out_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  psd_pkg::result_type  push_data,
   output logic                 push_ok,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output psd_pkg::result_type  pop_data
);
   import psd_pkg::*;

   result_type  entry_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff, count_in;
   logic        pop;

   assign pop       = pop_valid && pop_ready;
   assign pop_valid = count_ff != 2'd0;
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign push_ok   = count_ff != 2'd2 || pop_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop)      count_in = count_ff + 2'd1;
      else if (!push && pop) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: sv/psd_checker.sv
// ----------------------------------------------------------------------------
// psd_checker
// Port-level checks on the demux result channel.
// ----------------------------------------------------------------------------
module psd_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [1:0]                       rsp_kind,
   input logic [7:0]                       rsp_byte,
   input logic [psd_pkg::STAMP_W-1:0]      rsp_pts,
   input logic [psd_pkg::STAMP_W-1:0]      rsp_dts,
   input logic [psd_pkg::UNIT_LEN_W-1:0]   rsp_len
);
   import psd_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_byte)
         && $stable(rsp_len))
      else $error("result word changed while stalled");

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word right after reset");

   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_PAYLOAD |->
         rsp_pts == '0 && rsp_dts == '0 && rsp_len == '0)
      else $error("payload word carries unit fields");

   a_unit_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_DONE || rsp_kind == KIND_ABANDON) |->
         rsp_byte == 8'd0)
      else $error("unit word carries a payload byte");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind == KIND_PAYLOAD || rsp_kind == KIND_DONE
         || rsp_kind == KIND_ABANDON)
      else $error("undefined result kind");

endmodule

bind program_stream_demux psd_checker u_psd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_port.valid),
   .rsp_ready (rsp_port.ready),
   .rsp_kind  (rsp_port.result_kind),
   .rsp_byte  (rsp_port.payload_byte),
   .rsp_pts   (rsp_port.presentation_stamp),
   .rsp_dts   (rsp_port.decode_stamp),
   .rsp_len   (rsp_port.unit_length)
);
